// ----- hw/rtl/hsd_pkg.sv -----
// hsd_pkg: constants and types shared by the stream decoder files.
// No dependencies.
package hsd_pkg;

    localparam int DEF_MAX_NODES   = 512;
    localparam int DEF_STACK_DEPTH = 256;

    localparam logic [7:0] INTERNAL_MARK = 8'h2A;
    localparam logic [7:0] ESCAPE_MARK   = 8'h5C;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [1:0] {
        PH_HDR0 = 2'd0,
        PH_HDR1 = 2'd1,
        PH_TREE = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_T_ALLOC = 9'b000000010,
        S_T_LINK  = 9'b000000100,
        S_T_PUSH  = 9'b000001000,
        S_T_FIN   = 9'b000010000,
        S_D_BIT   = 9'b000100000,
        S_D_CHILD = 9'b001000000,
        S_D_LEAF  = 9'b010000000,
        S_D_END   = 9'b100000000
    } state_t;

endpackage

// ----- hw/rtl/hsd_in_if.sv -----
// hsd_in_if: valid/ready channel that carries one compressed stream byte.
// No dependencies.
interface hsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       is_final;

    modport source (output valid, output byte_value, output is_final, input ready);
    modport sink   (input valid, input byte_value, input is_final, output ready);
endinterface

// ----- hw/rtl/hsd_out_if.sv -----
// hsd_out_if: valid/ready channel that carries one decoded symbol.
// No dependencies.
interface hsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_in_run;

    modport source (output valid, output symbol, output last_in_run, input ready);
    modport sink   (input valid, input symbol, input last_in_run, output ready);
endinterface

// ----- hw/rtl/huffman_stream_decoder.sv -----
// huffman_stream_decoder: header parse, tree build and bit walk of a Huffman stream.
// Depends on hsd_pkg, hsd_in_if and hsd_out_if.
//
//   channel  | dir | payload                   | item
//   coded    | in  | byte_value[8], is_final   | one stream byte
//   decoded  | out | symbol[8], last_in_run    | one decoded symbol
//
// Header bytes are taken in the idle state. A tree byte is accepted, then takes the
// node write, parent link, stack push and count steps that it needs. A data byte
// goes through child read, leaf read and leaf check for each coded bit, then ends;
// with an empty or one-leaf tree each bit is a single step.
// coded.ready is high only between items. An output register plus one held
// symbol decouple the sides; a stalled decoded channel holds the walk.
// Reset clears control state only; the node table and stack need no clearing.
module huffman_stream_decoder #(
    parameter int MAX_NODES   = hsd_pkg::DEF_MAX_NODES,
    parameter int STACK_DEPTH = hsd_pkg::DEF_STACK_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    hsd_in_if.sink        coded,
    hsd_out_if.source     decoded
);
    import hsd_pkg::*;

    localparam int IW  = $clog2(MAX_NODES);
    localparam int NUW = $clog2(MAX_NODES + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int STW = $clog2(STACK_DEPTH + 1);

    logic [IW-1:0] left_mem  [MAX_NODES];
    logic [IW-1:0] right_mem [MAX_NODES];
    logic [8:0]    leaf_mem  [MAX_NODES];
    logic [IW:0]   stack_mem [STACK_DEPTH];

    state_t         state_reg, state_next;
    phase_t         phase_reg, phase_next;
    logic [2:0]     pad_reg, pad_next;
    logic [12:0]    tl_reg, tl_next;
    logic           esc_reg, esc_next;
    logic [NUW-1:0] nu_reg, nu_next;
    logic [STW-1:0] top_reg, top_next;
    logic [IW-1:0]  cur_reg, cur_next;
    logic           root_leaf_reg, root_leaf_next;
    logic [7:0]     root_sym_reg, root_sym_next;
    logic [7:0]     byte_reg, byte_next;
    logic           fin_reg, fin_next;
    logic           int_reg, int_next;
    logic [IW-1:0]  new_reg, new_next;
    logic [3:0]     bits_reg, bits_next;
    logic           pend_v_reg, pend_v_next;
    logic [7:0]     pend_sym_reg, pend_sym_next;
    logic           out_v_reg, out_v_next;
    logic [7:0]     out_sym_reg, out_sym_next;
    logic           out_last_reg, out_last_next;

    logic [IW-1:0] left_rd_reg, right_rd_reg;
    logic [8:0]    leaf_rd_reg;
    logic [IW:0]   stack_rd_reg;

    logic          node_re, leaf_re, stack_re;
    logic [IW-1:0] node_raddr, leaf_raddr;
    logic [SAW-1:0] stack_raddr, stack_waddr;
    logic          left_we, right_we, leaf_we, stack_we;
    logic [IW-1:0] left_waddr, right_waddr, leaf_waddr;
    logic [IW-1:0] left_wdata, right_wdata;
    logic [8:0]    leaf_wdata;
    logic [IW:0]   stack_wdata;

    logic          accept, can_push, is_int, do_add;
    logic [IW-1:0] nxt, cur_ok;
    logic [12:0]   tl_dec;
    logic [STW-1:0] top_m1;

    always_ff @(posedge clk)
    begin
        if (left_we)
        begin
            left_mem[left_waddr] <= left_wdata;
        end
        if (right_we)
        begin
            right_mem[right_waddr] <= right_wdata;
        end
        if (leaf_we)
        begin
            leaf_mem[leaf_waddr] <= leaf_wdata;
        end
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (node_re)
        begin
            left_rd_reg  <= left_mem[node_raddr];
            right_rd_reg <= right_mem[node_raddr];
        end
        if (leaf_re)
        begin
            leaf_rd_reg <= leaf_mem[leaf_raddr];
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_mem[stack_raddr];
        end
    end

    assign coded.ready         = (state_reg == S_IDLE);
    assign accept              = coded.valid && coded.ready;
    assign decoded.valid       = out_v_reg;
    assign decoded.symbol      = out_sym_reg;
    assign decoded.last_in_run = out_last_reg;
    assign can_push            = !out_v_reg || decoded.ready;

    assign is_int  = !esc_reg && (coded.byte_value == INTERNAL_MARK);
    assign do_add  = (esc_reg || (coded.byte_value != ESCAPE_MARK))
                     && (nu_reg < NUW'(MAX_NODES))
                     && !((nu_reg != '0) && (top_reg == '0))
                     && !(is_int && (top_reg >= STW'(STACK_DEPTH)));
    assign tl_dec  = tl_reg - 13'd1;
    assign top_m1  = top_reg - STW'(1);
    assign cur_ok  = (NUW'(cur_reg) < nu_reg) ? cur_reg : '0;
    assign nxt     = (NUW'(byte_reg[7] ? right_rd_reg : left_rd_reg) < nu_reg)
                     ? (byte_reg[7] ? right_rd_reg : left_rd_reg) : '0;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        pad_next      = pad_reg;
        tl_next       = tl_reg;
        esc_next      = esc_reg;
        nu_next       = nu_reg;
        top_next      = top_reg;
        cur_next      = cur_reg;
        root_leaf_next = root_leaf_reg;
        root_sym_next = root_sym_reg;
        byte_next     = byte_reg;
        fin_next      = fin_reg;
        int_next      = int_reg;
        new_next      = new_reg;
        bits_next     = bits_reg;
        pend_v_next   = pend_v_reg;
        pend_sym_next = pend_sym_reg;
        out_v_next    = out_v_reg && !decoded.ready;
        out_sym_next  = out_sym_reg;
        out_last_next = out_last_reg;

        node_re     = 1'b0;
        node_raddr  = cur_ok;
        leaf_re     = 1'b0;
        leaf_raddr  = nxt;
        stack_re    = 1'b0;
        stack_raddr = top_m1[SAW-1:0];
        left_we     = 1'b0;
        left_waddr  = new_reg;
        left_wdata  = '0;
        right_we    = 1'b0;
        right_waddr = new_reg;
        right_wdata = '0;
        leaf_we     = 1'b0;
        leaf_waddr  = new_reg;
        leaf_wdata  = {!int_reg, byte_reg};
        stack_we    = 1'b0;
        stack_waddr = top_reg[SAW-1:0];
        stack_wdata = {new_reg, 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    byte_next = coded.byte_value;
                    fin_next  = coded.is_final;
                    case (phase_reg)
                        PH_HDR0:
                        begin
                            nu_next    = '0;
                            top_next   = '0;
                            esc_next   = 1'b0;
                            cur_next   = '0;
                            pad_next   = coded.byte_value[7:5];
                            tl_next    = {coded.byte_value[4:0], 8'h00};
                            phase_next = coded.is_final ? PH_HDR0 : PH_HDR1;
                        end
                        PH_HDR1:
                        begin
                            tl_next = tl_reg | {5'd0, coded.byte_value};
                            if (coded.is_final)
                            begin
                                phase_next = PH_HDR0;
                                esc_next   = 1'b0;
                                cur_next   = '0;
                            end
                            else
                            begin
                                phase_next = ((tl_reg | {5'd0, coded.byte_value}) == '0)
                                             ? PH_DATA : PH_TREE;
                            end
                        end
                        PH_TREE:
                        begin
                            int_next = is_int;
                            new_next = nu_reg[IW-1:0];
                            if (do_add)
                            begin
                                esc_next   = 1'b0;
                                state_next = S_T_ALLOC;
                            end
                            else
                            begin
                                if (!esc_reg && (coded.byte_value == ESCAPE_MARK))
                                begin
                                    esc_next = 1'b1;
                                end
                                else
                                begin
                                    esc_next = 1'b0;
                                end
                                state_next = S_T_FIN;
                            end
                        end
                        default:
                        begin
                            bits_next = (coded.is_final && (pad_reg != '0))
                                        ? (BITS_PER_BYTE - {1'b0, pad_reg})
                                        : BITS_PER_BYTE;
                            state_next = S_D_BIT;
                        end
                    endcase
                end
            end
            S_T_ALLOC:
            begin
                left_we  = 1'b1;
                right_we = 1'b1;
                leaf_we  = 1'b1;
                nu_next  = nu_reg + NUW'(1);
                if (new_reg == '0)
                begin
                    root_leaf_next = !int_reg;
                    root_sym_next  = byte_reg;
                    state_next     = int_reg ? S_T_PUSH : S_T_FIN;
                end
                else
                begin
                    stack_re   = 1'b1;
                    state_next = S_T_LINK;
                end
            end
            S_T_LINK:
            begin
                if (!stack_rd_reg[0])
                begin
                    left_we     = 1'b1;
                    left_waddr  = stack_rd_reg[IW:1];
                    left_wdata  = new_reg;
                    stack_we    = 1'b1;
                    stack_waddr = top_m1[SAW-1:0];
                    stack_wdata = {stack_rd_reg[IW:1], 1'b1};
                end
                else
                begin
                    right_we    = 1'b1;
                    right_waddr = stack_rd_reg[IW:1];
                    right_wdata = new_reg;
                    top_next    = top_m1;
                end
                state_next = int_reg ? S_T_PUSH : S_T_FIN;
            end
            S_T_PUSH:
            begin
                stack_we   = 1'b1;
                top_next   = top_reg + STW'(1);
                state_next = S_T_FIN;
            end
            S_T_FIN:
            begin
                tl_next = tl_dec;
                if (tl_dec == '0)
                begin
                    esc_next   = 1'b0;
                    cur_next   = '0;
                    phase_next = PH_DATA;
                end
                if (fin_reg)
                begin
                    esc_next   = 1'b0;
                    cur_next   = '0;
                    phase_next = PH_HDR0;
                end
                state_next = S_IDLE;
            end
            S_D_BIT:
            begin
                if (bits_reg == '0)
                begin
                    state_next = S_D_END;
                end
                else if (nu_reg == '0)
                begin
                    byte_next = {byte_reg[6:0], 1'b0};
                    bits_next = bits_reg - 4'd1;
                end
                else if (root_leaf_reg)
                begin
                    if (!pend_v_reg || can_push)
                    begin
                        if (pend_v_reg)
                        begin
                            out_v_next    = 1'b1;
                            out_sym_next  = pend_sym_reg;
                            out_last_next = 1'b0;
                        end
                        pend_v_next   = 1'b1;
                        pend_sym_next = root_sym_reg;
                        byte_next     = {byte_reg[6:0], 1'b0};
                        bits_next     = bits_reg - 4'd1;
                    end
                end
                else
                begin
                    node_re    = 1'b1;
                    state_next = S_D_CHILD;
                end
            end
            S_D_CHILD:
            begin
                leaf_re    = 1'b1;
                cur_next   = nxt;
                state_next = S_D_LEAF;
            end
            S_D_LEAF:
            begin
                if (!leaf_rd_reg[8])
                begin
                    byte_next  = {byte_reg[6:0], 1'b0};
                    bits_next  = bits_reg - 4'd1;
                    state_next = S_D_BIT;
                end
                else if (!pend_v_reg || can_push)
                begin
                    if (pend_v_reg)
                    begin
                        out_v_next    = 1'b1;
                        out_sym_next  = pend_sym_reg;
                        out_last_next = 1'b0;
                    end
                    pend_v_next   = 1'b1;
                    pend_sym_next = leaf_rd_reg[7:0];
                    cur_next      = '0;
                    byte_next     = {byte_reg[6:0], 1'b0};
                    bits_next     = bits_reg - 4'd1;
                    state_next    = S_D_BIT;
                end
            end
            S_D_END:
            begin
                if (!pend_v_reg || can_push)
                begin
                    if (pend_v_reg)
                    begin
                        out_v_next    = 1'b1;
                        out_sym_next  = pend_sym_reg;
                        out_last_next = 1'b1;
                    end
                    pend_v_next = 1'b0;
                    if (fin_reg)
                    begin
                        phase_next = PH_HDR0;
                        esc_next   = 1'b0;
                        cur_next   = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_HDR0;
            pad_reg       <= '0;
            tl_reg        <= '0;
            esc_reg       <= 1'b0;
            nu_reg        <= '0;
            top_reg       <= '0;
            cur_reg       <= '0;
            root_leaf_reg <= 1'b0;
            fin_reg       <= 1'b0;
            int_reg       <= 1'b0;
            bits_reg      <= '0;
            pend_v_reg    <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pad_reg       <= pad_next;
            tl_reg        <= tl_next;
            esc_reg       <= esc_next;
            nu_reg        <= nu_next;
            top_reg       <= top_next;
            cur_reg       <= cur_next;
            root_leaf_reg <= root_leaf_next;
            fin_reg       <= fin_next;
            int_reg       <= int_next;
            bits_reg      <= bits_next;
            pend_v_reg    <= pend_v_next;
            out_v_reg     <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_sym_reg  <= root_sym_next;
        byte_reg      <= byte_next;
        new_reg       <= new_next;
        pend_sym_reg  <= pend_sym_next;
        out_sym_reg   <= out_sym_next;
        out_last_reg  <= out_last_next;
    end

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_v_reg)
        else $error("held symbol left over between items");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= STW'(STACK_DEPTH))
        else $error("build stack overflow");

    a_nodes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nu_reg <= NUW'(MAX_NODES))
        else $error("node table overflow");

    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_D_BIT) |-> (bits_reg <= BITS_PER_BYTE))
        else $error("bit count out of range");

endmodule
